### design/zkg_pkg.sv
// Shared constants, types and key tables for the Zobrist key generator.
`default_nettype none
package zkg_pkg;

  // Query codes
  localparam logic [1:0] OP_PIECE  = 2'd0;
  localparam logic [1:0] OP_SIDE   = 2'd1;
  localparam logic [1:0] OP_CASTLE = 2'd2;
  localparam logic [1:0] OP_EP     = 2'd3;

  // Finalizer constants
  localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MUL1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MUL2   = 64'h94d049bb133111eb;
  localparam int unsigned SHIFT1 = 30;
  localparam int unsigned SHIFT2 = 27;
  localparam int unsigned SHIFT3 = 31;

  // Seeds
  localparam logic [63:0] PIECE_SEED  = 64'h4154524f504f5300;
  localparam logic [63:0] SIDE_SEED   = 64'h4154524f504f53f0;
  localparam logic [63:0] CASTLE_SEED = 64'h4154524f504f5400;
  localparam logic [63:0] EP_SEED     = 64'h4154524f504f5500;

  // Control that travels with each request through the pipeline
  typedef struct packed {
    logic valid;
    logic mix;
  } zkg_ctl_t;

  // Full finalizer, evaluated on constants only
  function automatic logic [63:0] mix64_f(input logic [63:0] v);
    logic [63:0] t;
    t = v + GOLDEN;
    t = (t ^ (t >> SHIFT1)) * MUL1;
    t = (t ^ (t >> SHIFT2)) * MUL2;
    return t ^ (t >> SHIFT3);
  endfunction

  // Keys for the eight en passant files
  function automatic logic [7:0][63:0] ep_keys_f();
    logic [7:0][63:0] k;
    for (int i = 0; i < 8; i++) begin
      k[i] = mix64_f(EP_SEED + 64'(i));
    end
    return k;
  endfunction

  // Piece path starts from the seed with the golden increment folded in
  localparam logic [63:0] PIECE_BASE = PIECE_SEED + GOLDEN;

  localparam logic [63:0] TURN_KEY = mix64_f(SIDE_SEED);
  localparam logic [63:0] CASTLE_WK = mix64_f(CASTLE_SEED + 64'd1);
  localparam logic [63:0] CASTLE_WQ = mix64_f(CASTLE_SEED + 64'd2);
  localparam logic [63:0] CASTLE_BK = mix64_f(CASTLE_SEED + 64'd3);
  localparam logic [63:0] CASTLE_BQ = mix64_f(CASTLE_SEED + 64'd4);
  localparam logic [7:0][63:0] EP_KEYS = ep_keys_f();

endpackage
`default_nettype wire

### design/zkg_seed.sv
// Entry stage: decodes the request and forms the finalizer input or a finished key.
`default_nettype none
module zkg_seed (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic [1:0]           in_operation,
  input  wire logic                 in_piece_color,
  input  wire logic [2:0]           in_piece_type,
  input  wire logic [5:0]           in_square,
  input  wire logic                 in_castle_wk,
  input  wire logic                 in_castle_wq,
  input  wire logic                 in_castle_bk,
  input  wire logic                 in_castle_bq,
  input  wire logic                 in_ep_present,
  input  wire logic                 down_ld,
  output      logic                 up_ld,
  output      zkg_pkg::zkg_ctl_t    ctl_o,
  output      logic [63:0]          data_o
);
  import zkg_pkg::*;

  logic        valid_r;
  logic        mix_r;
  logic        mix_nxt;
  logic [63:0] data_r;
  logic [63:0] data_nxt;
  logic [3:0]  idx;

  // Piece index: color * 6 + type
  assign idx = in_piece_color ? ({1'b0, in_piece_type} + 4'd6) : {1'b0, in_piece_type};

  // Select finalizer input or a precomputed key
  always_comb begin
    mix_nxt  = 1'b0;
    data_nxt = '0;
    case (in_operation)
      OP_PIECE: begin
        mix_nxt  = 1'b1;
        data_nxt = PIECE_BASE + {54'd0, idx, in_square};
      end
      OP_SIDE: begin
        data_nxt = TURN_KEY;
      end
      OP_CASTLE: begin
        data_nxt = (in_castle_wk ? CASTLE_WK : 64'd0)
                 ^ (in_castle_wq ? CASTLE_WQ : 64'd0)
                 ^ (in_castle_bk ? CASTLE_BK : 64'd0)
                 ^ (in_castle_bq ? CASTLE_BQ : 64'd0);
      end
      OP_EP: begin
        data_nxt = in_ep_present ? EP_KEYS[in_square[2:0]] : 64'd0;
      end
      default: begin
        data_nxt = '0;
      end
    endcase
  end

  // Load when empty or when the next stage takes the current request
  assign up_ld = !valid_r || down_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ld) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ld) begin
      mix_r  <= mix_nxt;
      data_r <= data_nxt;
    end
  end

  assign ctl_o.valid = valid_r;
  assign ctl_o.mix   = mix_r;
  assign data_o      = data_r;

endmodule
`default_nettype wire

### design/zkg_round.sv
// One xor-shift-multiply round split into a partial-product stage and a sum stage.
`default_nettype none
module zkg_round #(
  parameter int unsigned SHIFT_AMT = zkg_pkg::SHIFT1,
  parameter logic [63:0] MULT_K    = zkg_pkg::MUL1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire zkg_pkg::zkg_ctl_t    ctl_i,
  input  wire logic [63:0]          data_i,
  input  wire logic                 down_ld,
  output      logic                 up_ld,
  output      zkg_pkg::zkg_ctl_t    ctl_o,
  output      logic [63:0]          data_o
);
  import zkg_pkg::*;

  localparam logic [31:0] K_LO = MULT_K[31:0];
  localparam logic [31:0] K_HI = MULT_K[63:32];

  logic        va_r;
  logic        ma_r;
  logic [63:0] pp0_r;
  logic [63:0] pp0_nxt;
  logic [31:0] pp1_r;
  logic [31:0] pp1_nxt;
  logic [31:0] pp2_r;
  logic [31:0] pp2_nxt;
  logic        vb_r;
  logic        mb_r;
  logic [63:0] sum_r;
  logic [63:0] sum_nxt;
  logic [63:0] x;
  logic        ld_a;
  logic        ld_b;

  // Stall chain
  assign ld_b  = !vb_r || down_ld;
  assign ld_a  = !va_r || ld_b;
  assign up_ld = ld_a;

  // Xor-shift, then three 32-bit partial products of the low 64-bit product;
  // a bypassed key rides in pp0 with the cross terms zeroed
  assign x = ctl_i.mix ? (data_i ^ (data_i >> SHIFT_AMT)) : data_i;

  always_comb begin
    if (ctl_i.mix) begin
      pp0_nxt = {32'd0, x[31:0]} * {32'd0, K_LO};
      pp1_nxt = x[63:32] * K_LO;
      pp2_nxt = x[31:0] * K_HI;
    end else begin
      pp0_nxt = x;
      pp1_nxt = '0;
      pp2_nxt = '0;
    end
  end

  // Combine partial products
  assign sum_nxt = pp0_r + {pp1_r + pp2_r, 32'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (ld_a) begin
        va_r <= ctl_i.valid;
      end
      if (ld_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      ma_r  <= ctl_i.mix;
      pp0_r <= pp0_nxt;
      pp1_r <= pp1_nxt;
      pp2_r <= pp2_nxt;
    end
    if (ld_b) begin
      mb_r  <= ma_r;
      sum_r <= sum_nxt;
    end
  end

  assign ctl_o.valid = vb_r;
  assign ctl_o.mix   = mb_r;
  assign data_o      = sum_r;

endmodule
`default_nettype wire

### design/zobrist_key_generator_unit.sv
// Top level of the Zobrist key generator: entry stage, two multiply rounds, output register.
// Accepts one request per cycle while in_stall is low and returns one 64-bit key per
// request, in order. A request passes one decode stage, two finalizer rounds of two
// stages each (32-bit partial products, then their sum), and the output register that
// applies the closing xor-shift. Side, castling and en passant keys come from constant
// tables and ride the same stages, so order is kept. A stall at the output fills empty
// stages before in_stall rises; with a full pipeline the block holds six requests.
`default_nettype none
module zobrist_key_generator_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic        in_piece_color,
  input  wire logic [2:0]  in_piece_type,
  input  wire logic [5:0]  in_square,
  input  wire logic        in_castle_wk,
  input  wire logic        in_castle_wq,
  input  wire logic        in_castle_bk,
  input  wire logic        in_castle_bq,
  input  wire logic        in_ep_present,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [63:0] out_hash_key
);
  import zkg_pkg::*;

  zkg_ctl_t    seed_ctl;
  zkg_ctl_t    r1_ctl;
  zkg_ctl_t    r2_ctl;
  logic [63:0] seed_data;
  logic [63:0] r1_data;
  logic [63:0] r2_data;
  logic        seed_ld;
  logic        r1_ld;
  logic        r2_ld;
  logic        out_ld;
  logic        out_valid_r;
  logic [63:0] out_hash_key_r;
  logic [63:0] out_hash_key_nxt;

  // Decode and seed
  zkg_seed u_seed (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_operation   (in_operation),
    .in_piece_color (in_piece_color),
    .in_piece_type  (in_piece_type),
    .in_square      (in_square),
    .in_castle_wk   (in_castle_wk),
    .in_castle_wq   (in_castle_wq),
    .in_castle_bk   (in_castle_bk),
    .in_castle_bq   (in_castle_bq),
    .in_ep_present  (in_ep_present),
    .down_ld        (r1_ld),
    .up_ld          (seed_ld),
    .ctl_o          (seed_ctl),
    .data_o         (seed_data)
  );

  // First finalizer round
  zkg_round #(
    .SHIFT_AMT (SHIFT1),
    .MULT_K    (MUL1)
  ) u_round1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (seed_ctl),
    .data_i  (seed_data),
    .down_ld (r2_ld),
    .up_ld   (r1_ld),
    .ctl_o   (r1_ctl),
    .data_o  (r1_data)
  );

  // Second finalizer round
  zkg_round #(
    .SHIFT_AMT (SHIFT2),
    .MULT_K    (MUL2)
  ) u_round2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (r1_ctl),
    .data_i  (r1_data),
    .down_ld (out_ld),
    .up_ld   (r2_ld),
    .ctl_o   (r2_ctl),
    .data_o  (r2_data)
  );

  // Output register: closing xor-shift
  assign out_ld           = !out_valid_r || !out_stall;
  assign out_hash_key_nxt = r2_ctl.mix ? (r2_data ^ (r2_data >> SHIFT3)) : r2_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= r2_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_hash_key_r <= out_hash_key_nxt;
    end
  end

  assign in_stall     = !seed_ld;
  assign out_valid    = out_valid_r;
  assign out_hash_key = out_hash_key_r;

  // An open output lets every stage advance
  a_no_stall_when_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

  // Input stalls only when every stage holds a request
  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && seed_ctl.valid && r1_ctl.valid && r2_ctl.valid))
    else $error("input stalled with an empty stage");

  // A blocked result stays valid
  a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_hash_key_r))
    else $error("blocked result lost");

endmodule
`default_nettype wire
